### rtl/core/ate_pkg.sv
// Shared types, codes and color maps for the ANSI text terminal engine.
// No dependencies; the SGR unit, the engine and the testbench import this package.
`timescale 1ns / 1ps
package ate_pkg;

    // Sequencer states of the engine
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SGR,
        ST_COPY,
        ST_FILL,
        ST_TAB,
        ST_EMIT
    } t_state;

    // Escape parser states
    typedef enum logic [2:0] {
        PS_NORMAL,
        PS_ESC,
        PS_CSI,
        PS_OSC,
        PS_OSC_ESC
    } t_pstate;

    // One SGR parameter handed to the attribute unit
    typedef struct packed {
        logic        step;
        logic [15:0] param;
    } t_sgr_req;

    localparam logic [15:0] CELL_RESET = 16'h0720;
    localparam logic [7:0]  ATTR_RESET = 8'h07;

    // Control and plain bytes
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_SAVE   = 8'h37;
    localparam logic [7:0] CH_REST   = 8'h38;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // CSI final bytes
    localparam logic [7:0] FIN_UP     = 8'h41;
    localparam logic [7:0] FIN_DOWN   = 8'h42;
    localparam logic [7:0] FIN_RIGHT  = 8'h43;
    localparam logic [7:0] FIN_LEFT   = 8'h44;
    localparam logic [7:0] FIN_NEXTL  = 8'h45;
    localparam logic [7:0] FIN_PREVL  = 8'h46;
    localparam logic [7:0] FIN_COLUMN = 8'h47;
    localparam logic [7:0] FIN_POS    = 8'h48;
    localparam logic [7:0] FIN_EDISP  = 8'h4A;
    localparam logic [7:0] FIN_ELINE  = 8'h4B;
    localparam logic [7:0] FIN_SCRUP  = 8'h53;
    localparam logic [7:0] FIN_SCRDN  = 8'h54;
    localparam logic [7:0] FIN_POS2   = 8'h66;
    localparam logic [7:0] FIN_SET    = 8'h68;
    localparam logic [7:0] FIN_RESET  = 8'h6C;
    localparam logic [7:0] FIN_SGR    = 8'h6D;
    localparam logic [7:0] FIN_SAVE   = 8'h73;
    localparam logic [7:0] FIN_REST   = 8'h75;

    // SGR codes
    localparam logic [15:0] SGR_CLEAR   = 16'd0;
    localparam logic [15:0] SGR_BOLD    = 16'd1;
    localparam logic [15:0] SGR_REV     = 16'd7;
    localparam logic [15:0] SGR_NOBOLD  = 16'd22;
    localparam logic [15:0] SGR_NOREV   = 16'd27;
    localparam logic [15:0] SGR_FG_LO   = 16'd30;
    localparam logic [15:0] SGR_FG_HI   = 16'd37;
    localparam logic [15:0] SGR_FG_DEF  = 16'd39;
    localparam logic [15:0] SGR_BG_LO   = 16'd40;
    localparam logic [15:0] SGR_BG_HI   = 16'd47;
    localparam logic [15:0] SGR_BG_DEF  = 16'd49;
    localparam logic [15:0] SGR_FGB_LO  = 16'd90;
    localparam logic [15:0] SGR_FGB_HI  = 16'd97;
    localparam logic [15:0] SGR_BGB_LO  = 16'd100;
    localparam logic [15:0] SGR_BGB_HI  = 16'd107;

    // Private mode numbers
    localparam logic [15:0] PRIV_CURSOR  = 16'd25;
    localparam logic [15:0] PRIV_ALT     = 16'd1049;
    localparam logic [15:0] PRIV_ALT_OLD = 16'd47;

    // ANSI color index to CGA palette
    function automatic logic [3:0] normal_map(input logic [2:0] idx);
        logic [3:0] v;
        case (idx)
            3'd0: v = 4'd0;
            3'd1: v = 4'd4;
            3'd2: v = 4'd2;
            3'd3: v = 4'd6;
            3'd4: v = 4'd1;
            3'd5: v = 4'd5;
            3'd6: v = 4'd3;
            default: v = 4'd7;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] bright_map(input logic [2:0] idx);
        return normal_map(idx) | 4'd8;
    endfunction

endpackage

### rtl/core/ate_if.sv
// Valid/ready channel interfaces for terminal items and result items.
// Fixed payload widths; no package dependency.
`timescale 1ns / 1ps
interface ate_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  char_byte;
    logic [10:0] cell_address;

    modport source(output valid, command, char_byte, cell_address, input ready);
    modport sink(input valid, command, char_byte, cell_address, output ready);
endinterface

interface ate_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        cursor_visible;
    logic        alt_screen_on;
    logic [7:0]  current_attribute;

    modport source(output valid, cell_value, cursor_row, cursor_col, cursor_visible,
                   alt_screen_on, current_attribute, input ready);
    modport sink(input valid, cell_value, cursor_row, cursor_col, cursor_visible,
                 alt_screen_on, current_attribute, output ready);
endinterface

### rtl/core/ate_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module ate_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/ate_sgr.sv
// SGR attribute unit: steps one parameter a cycle and holds colors and flags.
// Depends on ate_pkg.
`timescale 1ns / 1ps
module ate_sgr
    import ate_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_sgr_req i_req,
    output logic [7:0] o_attr
);
    logic [3:0] r_fg, n_fg;
    logic [3:0] r_bg, n_bg;
    logic       r_bold, n_bold;
    logic       r_rev, n_rev;

    // Hold color state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg   <= 4'd7;
            r_bg   <= 4'd0;
            r_bold <= 1'b0;
            r_rev  <= 1'b0;
        end else begin
            r_fg   <= n_fg;
            r_bg   <= n_bg;
            r_bold <= n_bold;
            r_rev  <= n_rev;
        end
    end

    // Apply one parameter
    always_comb begin
        logic [15:0] p;
        logic [2:0]  fi;
        logic [2:0]  bi;
        logic [2:0]  hi;
        logic [2:0]  gi;
        p      = i_req.param;
        fi     = 3'(p - SGR_FG_LO);
        bi     = 3'(p - SGR_BG_LO);
        hi     = 3'(p - SGR_FGB_LO);
        gi     = 3'(p - SGR_BGB_LO);
        n_fg   = r_fg;
        n_bg   = r_bg;
        n_bold = r_bold;
        n_rev  = r_rev;
        if (i_req.step) begin
            if (p == SGR_CLEAR) begin
                n_fg   = 4'd7;
                n_bg   = 4'd0;
                n_bold = 1'b0;
                n_rev  = 1'b0;
            end else if (p == SGR_BOLD) begin
                n_bold = 1'b1;
            end else if (p == SGR_NOBOLD) begin
                n_bold = 1'b0;
            end else if (p == SGR_REV) begin
                n_rev = 1'b1;
            end else if (p == SGR_NOREV) begin
                n_rev = 1'b0;
            end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
                n_fg = r_bold ? bright_map(fi) : normal_map(fi);
            end else if (p == SGR_FG_DEF) begin
                n_fg = 4'd7;
            end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
                n_bg = normal_map(bi);
            end else if (p == SGR_BG_DEF) begin
                n_bg = 4'd0;
            end else if (p >= SGR_FGB_LO && p <= SGR_FGB_HI) begin
                n_fg = bright_map(hi);
            end else if (p >= SGR_BGB_LO && p <= SGR_BGB_HI) begin
                n_bg = bright_map(gi);
            end
        end
    end

    // Swap nibbles in reverse video
    assign o_attr = r_rev ? {r_fg, r_bg} : {r_bg, r_fg};
endmodule

### rtl/core/ansi_text_terminal_engine.sv
// ANSI text terminal engine: parser, cell sequencer and screen/alternate stores.
// A plain byte goes straight to the emit state; a cell read waits in the read state for
// the store; SGR steps its parameters, a tab writes its spaces, erase blanks its cells, and
// scroll and alternate-screen copies move the cells of the store (one RAM read and write
// per cycle) before the emit state loads the output register. Throughput: one item at a
// time, as input is ready only in the idle state. Reset: a clearing pass writes blanks
// over the whole screen store; no item is accepted until it ends.
`timescale 1ns / 1ps
module ansi_text_terminal_engine
    import ate_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25,
    parameter int MAX_PARAMS    = 8,
    parameter int TAB_STOP      = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ate_in_if.sink    i_in,
    ate_out_if.source o_out
);
    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(SCREEN_HEIGHT);
    localparam int RW1   = RW + 1;
    localparam int CLW   = $clog2(SCREEN_WIDTH);
    localparam int CLW1  = CLW + 1;
    localparam int PIW   = $clog2(MAX_PARAMS);
    localparam int PCW   = $clog2(MAX_PARAMS + 1);
    localparam int TW    = $clog2(TAB_STOP + 1);
    localparam int XW    = (AW > 11) ? AW : 11;

    t_state             r_state, n_state;
    t_pstate            r_ps, n_ps;
    logic [15:0]        r_par [MAX_PARAMS];
    logic [15:0]        n_par [MAX_PARAMS];
    logic [PCW-1:0]     r_pcnt, n_pcnt;
    logic               r_priv, n_priv;
    logic [RW-1:0]      r_row, n_row, r_srow, n_srow, r_arow, n_arow;
    logic [CLW-1:0]     r_col, n_col, r_scol, n_scol, r_acol, n_acol;
    logic               r_alt, n_alt;
    logic               r_curs, n_curs;
    logic [PIW-1:0]     r_si, n_si;
    logic [AW-1:0]      r_src, n_src, r_dst, n_dst, r_pdst, n_pdst;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_down, n_down, r_from_alt, n_from_alt, r_to_alt, n_to_alt;
    logic               r_pend, n_pend, r_fill_after, n_fill_after;
    logic [AW-1:0]      r_fa, n_fa, r_fe, n_fe;
    logic [TW-1:0]      r_tab, n_tab;
    logic               r_rd_ok, n_rd_ok;
    logic [15:0]        r_cell, n_cell;
    logic               r_ov, n_ov;
    logic [15:0]        r_o_cell, n_o_cell;
    logic [4:0]         r_o_row, n_o_row;
    logic [6:0]         r_o_col, n_o_col;
    logic               r_o_vis, n_o_vis, r_o_alt, n_o_alt;
    logic [7:0]         r_o_attr, n_o_attr;

    logic               s_we, a_we;
    logic [AW-1:0]      s_waddr, s_raddr, a_waddr, a_raddr;
    logic [15:0]        s_wdata, a_wdata, s_rdata, a_rdata;
    t_sgr_req           w_sgr_req;
    logic [7:0]         w_attr;
    logic [TW-1:0]      w_tab_lut [SCREEN_WIDTH];
    logic [AW-1:0]      w_rbase, w_here;
    logic [XW-1:0]      w_addr_x;
    logic               w_in_acc;
    logic [CLW1-1:0]    w_col1;
    logic [RW1-1:0]     w_row1;
    logic               w_wrap, w_bottom;
    logic [RW-1:0]      w_lf_row;

    // Screen and alternate stores
    ate_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    ate_ram #(.WIDTH(16), .DEPTH(CELLS)) u_alt (
        .i_clk  (i_clk),
        .i_we   (a_we),
        .i_waddr(a_waddr),
        .i_wdata(a_wdata),
        .i_raddr(a_raddr),
        .o_rdata(a_rdata)
    );

    ate_sgr u_sgr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_sgr_req),
        .o_attr (w_attr)
    );

    // Spaces to the next tab stop for each column
    for (genvar g = 0; g < SCREEN_WIDTH; g++) begin : g_tab
        assign w_tab_lut[g] = TW'(TAB_STOP - (g % TAB_STOP));
    end

    // Cursor address and advance
    assign w_rbase  = AW'(int'(r_row) * SCREEN_WIDTH);
    assign w_here   = w_rbase + AW'(r_col);
    assign w_col1   = CLW1'(r_col) + CLW1'(1);
    assign w_row1   = RW1'(r_row) + RW1'(1);
    assign w_wrap   = w_col1 >= CLW1'(SCREEN_WIDTH);
    assign w_bottom = w_row1 >= RW1'(SCREEN_HEIGHT);
    assign w_lf_row = w_bottom ? RW'(SCREEN_HEIGHT - 1) : w_row1[RW-1:0];
    assign w_addr_x = XW'(i_in.cell_address);
    assign w_in_acc = i_in.valid && i_in.ready;

    assign i_in.ready              = (r_state == ST_IDLE);
    assign o_out.valid             = r_ov;
    assign o_out.cell_value        = r_o_cell;
    assign o_out.cursor_row        = r_o_row;
    assign o_out.cursor_col        = r_o_col;
    assign o_out.cursor_visible    = r_o_vis;
    assign o_out.alt_screen_on     = r_o_alt;
    assign o_out.current_attribute = r_o_attr;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ps    <= PS_NORMAL;
            r_pcnt  <= '0;
            r_priv  <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_srow  <= '0;
            r_scol  <= '0;
            r_arow  <= '0;
            r_acol  <= '0;
            r_alt   <= 1'b0;
            r_curs  <= 1'b1;
            r_si    <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_fa    <= '0;
            r_tab   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                r_par[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ps    <= n_ps;
            r_pcnt  <= n_pcnt;
            r_priv  <= n_priv;
            r_row   <= n_row;
            r_col   <= n_col;
            r_srow  <= n_srow;
            r_scol  <= n_scol;
            r_arow  <= n_arow;
            r_acol  <= n_acol;
            r_alt   <= n_alt;
            r_curs  <= n_curs;
            r_si    <= n_si;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_fa    <= n_fa;
            r_tab   <= n_tab;
            r_ov    <= n_ov;
            r_par   <= n_par;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_pdst       <= n_pdst;
        r_down       <= n_down;
        r_from_alt   <= n_from_alt;
        r_to_alt     <= n_to_alt;
        r_fill_after <= n_fill_after;
        r_fe         <= n_fe;
        r_rd_ok      <= n_rd_ok;
        r_cell       <= n_cell;
        r_o_cell     <= n_o_cell;
        r_o_row      <= n_o_row;
        r_o_col      <= n_o_col;
        r_o_vis      <= n_o_vis;
        r_o_alt      <= n_o_alt;
        r_o_attr     <= n_o_attr;
    end

    // Parser, sequencer and store access
    always_comb begin
        logic [7:0]     c;
        logic [15:0]    p0, p1, cnt_n, g16, r16, k16;
        logic [16:0]    sum17;
        logic [19:0]    v20;
        logic [PCW-1:0] eff;
        logic [PIW-1:0] idx;
        logic [RW1-1:0] ns;
        logic [CW-1:0]  sc_shift;
        logic           sc_go, sc_down;
        t_state         done_st;

        c        = i_in.char_byte;
        p0       = r_par[0];
        p1       = r_par[1];
        cnt_n    = (p0 != 16'd0) ? p0 : 16'd1;
        g16      = (p0 != 16'd0) ? (p0 - 16'd1) : 16'd0;
        r16      = (p0 != 16'd0) ? p0 : 16'd1;
        k16      = (r_pcnt > PCW'(1) && p1 != 16'd0) ? p1 : 16'd1;
        sum17    = '0;
        v20      = '0;
        eff      = (r_pcnt == '0) ? PCW'(1) : r_pcnt;
        idx      = (r_pcnt == '0) ? '0 : PIW'(r_pcnt - PCW'(1));
        ns       = (cnt_n > 16'(SCREEN_HEIGHT)) ? RW1'(SCREEN_HEIGHT) : RW1'(cnt_n);
        sc_shift = CW'(SCREEN_WIDTH);
        sc_go    = 1'b0;
        sc_down  = 1'b0;
        done_st  = (r_tab != '0) ? ST_TAB : ST_EMIT;

        n_state      = r_state;
        n_ps         = r_ps;
        n_par        = r_par;
        n_pcnt       = r_pcnt;
        n_priv       = r_priv;
        n_row        = r_row;
        n_col        = r_col;
        n_srow       = r_srow;
        n_scol       = r_scol;
        n_arow       = r_arow;
        n_acol       = r_acol;
        n_alt        = r_alt;
        n_curs       = r_curs;
        n_si         = r_si;
        n_src        = r_src;
        n_dst        = r_dst;
        n_pdst       = r_pdst;
        n_cnt        = r_cnt;
        n_down       = r_down;
        n_from_alt   = r_from_alt;
        n_to_alt     = r_to_alt;
        n_pend       = 1'b0;
        n_fill_after = r_fill_after;
        n_fa         = r_fa;
        n_fe         = r_fe;
        n_tab        = r_tab;
        n_rd_ok      = r_rd_ok;
        n_cell       = r_cell;
        n_ov         = r_ov && !o_out.ready;
        n_o_cell     = r_o_cell;
        n_o_row      = r_o_row;
        n_o_col      = r_o_col;
        n_o_vis      = r_o_vis;
        n_o_alt      = r_o_alt;
        n_o_attr     = r_o_attr;

        s_we      = 1'b0;
        s_waddr   = w_here;
        s_wdata   = {w_attr, c};
        s_raddr   = r_src;
        a_we      = 1'b0;
        a_waddr   = r_pdst;
        a_wdata   = s_rdata;
        a_raddr   = r_src;
        w_sgr_req = '0;

        case (r_state)
            // Write blanks over the whole screen store after reset
            ST_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_fa;
                s_wdata = CELL_RESET;
                if (r_fa == AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_fa = r_fa + AW'(1);
                end
            end

            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.command) begin
                        s_raddr = w_addr_x[AW-1:0];
                        n_rd_ok = w_addr_x < XW'(CELLS);
                        n_state = ST_READ;
                    end else begin
                        n_cell  = '0;
                        n_state = ST_EMIT;
                        if (r_ps == PS_ESC) begin
                            n_ps = PS_NORMAL;
                            if (c == CH_LBRACK) begin
                                n_ps     = PS_CSI;
                                n_pcnt   = '0;
                                n_par[0] = '0;
                                n_priv   = 1'b0;
                            end else if (c == CH_RBRACK) begin
                                n_ps = PS_OSC;
                            end else if (c == CH_SAVE) begin
                                n_srow = r_row;
                                n_scol = r_col;
                            end else if (c == CH_REST) begin
                                n_row = r_srow;
                                n_col = r_scol;
                            end
                        end else if (r_ps == PS_OSC) begin
                            if (c == CH_BEL) begin
                                n_ps = PS_NORMAL;
                            end else if (c == CH_ESC) begin
                                n_ps = PS_OSC_ESC;
                            end
                        end else if (r_ps == PS_OSC_ESC) begin
                            n_ps = PS_NORMAL;
                        end else if (r_ps == PS_CSI) begin
                            if (c == CH_QMARK) begin
                                n_priv = 1'b1;
                            end else if (c >= CH_DIG0 && c <= CH_DIG9) begin
                                // Accumulate a digit, saturating
                                v20        = 20'(r_par[idx]) * 20'd10 + 20'(c - CH_DIG0);
                                n_par[idx] = (v20 > 20'd65535) ? 16'hFFFF : v20[15:0];
                                n_pcnt     = eff;
                            end else if (c == CH_SEMI) begin
                                n_pcnt = eff;
                                if (eff < PCW'(MAX_PARAMS)) begin
                                    n_par[PIW'(eff)] = '0;
                                    n_pcnt           = eff + PCW'(1);
                                end
                            end else begin
                                // Final byte
                                n_ps   = PS_NORMAL;
                                n_priv = 1'b0;
                                n_pcnt = eff;
                                case (c)
                                    FIN_SGR: begin
                                        n_si    = '0;
                                        n_state = ST_SGR;
                                    end
                                    FIN_POS, FIN_POS2: begin
                                        n_row = (r16 > 16'(SCREEN_HEIGHT)) ?
                                                RW'(SCREEN_HEIGHT - 1) : RW'(r16 - 16'd1);
                                        n_col = (k16 > 16'(SCREEN_WIDTH)) ?
                                                CLW'(SCREEN_WIDTH - 1) : CLW'(k16 - 16'd1);
                                    end
                                    FIN_EDISP: begin
                                        n_state = ST_FILL;
                                        if (p0 == 16'd1) begin
                                            n_fa = '0;
                                            n_fe = w_here;
                                        end else if (p0 == 16'd2 || p0 == 16'd3) begin
                                            n_fa = '0;
                                            n_fe = AW'(CELLS - 1);
                                        end else begin
                                            n_fa = w_here;
                                            n_fe = AW'(CELLS - 1);
                                        end
                                    end
                                    FIN_ELINE: begin
                                        n_state = ST_FILL;
                                        if (p0 == 16'd1) begin
                                            n_fa = w_rbase;
                                            n_fe = w_here;
                                        end else if (p0 == 16'd2) begin
                                            n_fa = w_rbase;
                                            n_fe = w_rbase + AW'(SCREEN_WIDTH - 1);
                                        end else begin
                                            n_fa = w_here;
                                            n_fe = w_rbase + AW'(SCREEN_WIDTH - 1);
                                        end
                                    end
                                    FIN_UP: begin
                                        n_row = (cnt_n > 16'(r_row)) ? '0 : r_row - RW'(cnt_n);
                                    end
                                    FIN_PREVL: begin
                                        n_row = (cnt_n > 16'(r_row)) ? '0 : r_row - RW'(cnt_n);
                                        n_col = '0;
                                    end
                                    FIN_DOWN, FIN_NEXTL: begin
                                        sum17 = 17'(r_row) + 17'(cnt_n);
                                        n_row = (sum17 >= 17'(SCREEN_HEIGHT)) ?
                                                RW'(SCREEN_HEIGHT - 1) : RW'(sum17);
                                        if (c == FIN_NEXTL) begin
                                            n_col = '0;
                                        end
                                    end
                                    FIN_RIGHT: begin
                                        sum17 = 17'(r_col) + 17'(cnt_n);
                                        n_col = (sum17 >= 17'(SCREEN_WIDTH)) ?
                                                CLW'(SCREEN_WIDTH - 1) : CLW'(sum17);
                                    end
                                    FIN_LEFT: begin
                                        n_col = (cnt_n > 16'(r_col)) ? '0 : r_col - CLW'(cnt_n);
                                    end
                                    FIN_COLUMN: begin
                                        n_col = (g16 >= 16'(SCREEN_WIDTH)) ?
                                                CLW'(SCREEN_WIDTH - 1) : CLW'(g16);
                                    end
                                    FIN_SCRUP, FIN_SCRDN: begin
                                        sc_go    = 1'b1;
                                        sc_down  = (c == FIN_SCRDN);
                                        sc_shift = CW'(int'(ns) * SCREEN_WIDTH);
                                    end
                                    FIN_SAVE: begin
                                        n_srow = r_row;
                                        n_scol = r_col;
                                    end
                                    FIN_REST: begin
                                        n_row = r_srow;
                                        n_col = r_scol;
                                    end
                                    FIN_SET, FIN_RESET: begin
                                        if (r_priv) begin
                                            if (p0 == PRIV_CURSOR) begin
                                                n_curs = (c == FIN_SET);
                                            end else if (p0 == PRIV_ALT ||
                                                         p0 == PRIV_ALT_OLD) begin
                                                if (c == FIN_SET && !r_alt) begin
                                                    // Save screen, then blank it
                                                    n_arow       = r_row;
                                                    n_acol       = r_col;
                                                    n_alt        = 1'b1;
                                                    n_row        = '0;
                                                    n_col        = '0;
                                                    n_src        = '0;
                                                    n_dst        = '0;
                                                    n_cnt        = CW'(CELLS);
                                                    n_down       = 1'b0;
                                                    n_from_alt   = 1'b0;
                                                    n_to_alt     = 1'b1;
                                                    n_fill_after = 1'b1;
                                                    n_fa         = '0;
                                                    n_fe         = AW'(CELLS - 1);
                                                    n_state      = ST_COPY;
                                                end else if (c == FIN_RESET && r_alt) begin
                                                    // Restore saved screen
                                                    n_alt        = 1'b0;
                                                    n_row        = r_arow;
                                                    n_col        = r_acol;
                                                    n_src        = '0;
                                                    n_dst        = '0;
                                                    n_cnt        = CW'(CELLS);
                                                    n_down       = 1'b0;
                                                    n_from_alt   = 1'b1;
                                                    n_to_alt     = 1'b0;
                                                    n_fill_after = 1'b0;
                                                    n_state      = ST_COPY;
                                                end
                                            end
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end else begin
                            // Normal text
                            n_ps = PS_NORMAL;
                            if (c == CH_ESC) begin
                                n_ps = PS_ESC;
                            end else if (c == CH_LF) begin
                                n_col = '0;
                                n_row = w_lf_row;
                                sc_go = w_bottom;
                            end else if (c == CH_CR) begin
                                n_col = '0;
                            end else if (c == CH_BS) begin
                                if (r_col != '0) begin
                                    n_col   = r_col - CLW'(1);
                                    s_we    = 1'b1;
                                    s_waddr = w_here - AW'(1);
                                    s_wdata = {w_attr, CH_SPACE};
                                end
                            end else if (c == CH_TAB) begin
                                n_tab   = w_tab_lut[r_col];
                                n_state = ST_TAB;
                            end else begin
                                s_we = 1'b1;
                                if (w_wrap) begin
                                    n_col = '0;
                                    n_row = w_lf_row;
                                    sc_go = w_bottom;
                                end else begin
                                    n_col = w_col1[CLW-1:0];
                                end
                            end
                        end
                    end
                end
            end

            // Capture the read cell
            ST_READ: begin
                n_cell  = r_rd_ok ? s_rdata : 16'd0;
                n_state = ST_EMIT;
            end

            // Step SGR parameters one a cycle
            ST_SGR: begin
                w_sgr_req.step  = 1'b1;
                w_sgr_req.param = r_par[r_si];
                if (PCW'(r_si) + PCW'(1) == r_pcnt) begin
                    n_state = ST_EMIT;
                end else begin
                    n_si = r_si + PIW'(1);
                end
            end

            // Read ahead, write back in the next cycle
            ST_COPY: begin
                if (r_cnt != '0) begin
                    n_pend = 1'b1;
                    n_pdst = r_dst;
                    n_cnt  = r_cnt - CW'(1);
                    n_src  = r_down ? (r_src - AW'(1)) : (r_src + AW'(1));
                    n_dst  = r_down ? (r_dst - AW'(1)) : (r_dst + AW'(1));
                end
                if (r_pend) begin
                    if (r_to_alt) begin
                        a_we    = 1'b1;
                        a_waddr = r_pdst;
                        a_wdata = s_rdata;
                    end else begin
                        s_we    = 1'b1;
                        s_waddr = r_pdst;
                        s_wdata = r_from_alt ? a_rdata : s_rdata;
                    end
                end
                if (r_cnt == '0 && !r_pend) begin
                    n_state = r_fill_after ? ST_FILL : done_st;
                end
            end

            // Blank a range with the current attribute
            ST_FILL: begin
                s_we    = 1'b1;
                s_waddr = r_fa;
                s_wdata = {w_attr, CH_SPACE};
                if (r_fa == r_fe) begin
                    n_state = done_st;
                end else begin
                    n_fa = r_fa + AW'(1);
                end
            end

            // Put one tab space a cycle, pausing for a scroll at the bottom row
            ST_TAB: begin
                s_we    = 1'b1;
                s_wdata = {w_attr, CH_SPACE};
                n_tab   = r_tab - TW'(1);
                if (w_wrap) begin
                    n_col = '0;
                    n_row = w_lf_row;
                    sc_go = w_bottom;
                end else begin
                    n_col = w_col1[CLW-1:0];
                end
                if (!(w_wrap && w_bottom)) begin
                    n_state = (r_tab == TW'(1)) ? ST_EMIT : ST_TAB;
                end
            end

            // Hand the result to the output register
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov     = 1'b1;
                    n_o_cell = r_cell;
                    n_o_row  = 5'(r_row);
                    n_o_col  = 7'(r_col);
                    n_o_vis  = r_curs;
                    n_o_alt  = r_alt;
                    n_o_attr = w_attr;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Launch a scroll: copy rows, then blank the opened rows
        if (sc_go) begin
            n_cnt        = CW'(CELLS) - sc_shift;
            n_from_alt   = 1'b0;
            n_to_alt     = 1'b0;
            n_fill_after = 1'b1;
            n_down       = sc_down;
            n_state      = ST_COPY;
            if (sc_down) begin
                n_src = AW'(CW'(CELLS - 1) - sc_shift);
                n_dst = AW'(CELLS - 1);
                n_fa  = '0;
                n_fe  = AW'(sc_shift - CW'(1));
            end else begin
                n_src = AW'(sc_shift);
                n_dst = '0;
                n_fa  = AW'(CW'(CELLS) - sc_shift);
                n_fe  = AW'(CELLS - 1);
            end
        end
    end

    // Cursor stays on the screen
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < SCREEN_HEIGHT)
        else $error("cursor row beyond screen");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < SCREEN_WIDTH)
        else $error("cursor column beyond screen");

    // A read command always goes to the read state next, to wait for the store
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.command) |=> (r_state == ST_READ))
        else $error("read command skipped the store wait");

    // Copy write-back only happens inside a copy
    a_pend_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_COPY))
        else $error("pending copy write outside copy");

    // Fill pointer never passes its end
    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> (r_fa <= r_fe))
        else $error("fill pointer passed range end");
endmodule

### sim/tb_ansi_text_terminal_engine.sv
// Self-checking testbench for the ANSI text terminal engine: directed rows and random traffic.
// Depends on ate_pkg and the ate_in_if/ate_out_if interfaces; checks results against a
// behavioral screen and parser model kept here.
`timescale 1ns / 1ps
module tb_ansi_text_terminal_engine;
    import ate_pkg::*;

    localparam int W = 80;
    localparam int H = 25;
    localparam int NCELL = W * H;
    localparam int NPAR = 8;
    localparam int TABW = 4;
    localparam int N_ITEMS = 1150;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    typedef struct packed {
        logic        command;
        logic [7:0]  char_byte;
        logic [10:0] cell_address;
    } t_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        cursor_visible;
        logic        alt_screen_on;
        logic [7:0]  current_attribute;
    } t_view;

    // One directed row: item plus an optional typed-in expectation
    typedef struct {
        t_item item;
        bit    fixed;
        t_view view;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    ate_in_if  in_ch();
    ate_out_if out_ch();

    ansi_text_terminal_engine u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Terminal state mirror
    logic [15:0] scr [NCELL];
    logic [15:0] alt [NCELL];
    t_pstate     pst;
    int unsigned par [NPAR];
    int unsigned npar;
    bit          priv;
    logic [3:0]  fg, bg;
    bit          bold, rev;
    logic [7:0]  attr;
    int unsigned row, col, srow, scol, arow, acol;
    bit          alt_on, shown;

    t_view  pending_views[$];
    t_row   dir_rows[$];
    int     fails;
    int     n_sent;
    longint cycles;
    bit     feeding_done;

    function automatic logic [3:0] cga(input int unsigned idx, input bit hi);
        logic [3:0] m [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};
        return m[idx] | (hi ? 4'd8 : 4'd0);
    endfunction

    function automatic void blank_range(input int unsigned a, input int unsigned b);
        for (int unsigned i = a; i <= b && i < NCELL; i++) scr[i] = {attr, CH_SPACE};
    endfunction

    function automatic void roll_up(input int unsigned n);
        int unsigned sh;
        sh = n * W;
        if (n == 0) return;
        for (int unsigned i = 0; i + sh < NCELL; i++) scr[i] = scr[i + sh];
        blank_range(NCELL - sh, NCELL - 1);
    endfunction

    function automatic void roll_down(input int unsigned n);
        int unsigned sh;
        sh = n * W;
        if (n == 0) return;
        for (int unsigned i = NCELL; i > sh; i--) scr[i - 1] = scr[i - 1 - sh];
        blank_range(0, sh - 1);
    endfunction

    function automatic void new_line();
        col = 0;
        row++;
        if (row >= H) begin
            roll_up(1);
            row = H - 1;
        end
    endfunction

    function automatic void glyph(input logic [7:0] c);
        scr[row * W + col] = {attr, c};
        col++;
        if (col >= W) new_line();
    endfunction

    function automatic void run_sgr();
        int unsigned p;
        for (int unsigned i = 0; i < npar && i < NPAR; i++) begin
            p = par[i];
            if (p == SGR_CLEAR) begin
                fg = 7; bg = 0; bold = 0; rev = 0;
            end else if (p == SGR_BOLD) bold = 1;
            else if (p == SGR_NOBOLD) bold = 0;
            else if (p == SGR_REV) rev = 1;
            else if (p == SGR_NOREV) rev = 0;
            else if (p >= SGR_FG_LO && p <= SGR_FG_HI) fg = cga(p - SGR_FG_LO, bold);
            else if (p == SGR_FG_DEF) fg = 7;
            else if (p >= SGR_BG_LO && p <= SGR_BG_HI) bg = cga(p - SGR_BG_LO, 0);
            else if (p == SGR_BG_DEF) bg = 0;
            else if (p >= SGR_FGB_LO && p <= SGR_FGB_HI) fg = cga(p - SGR_FGB_LO, 1);
            else if (p >= SGR_BGB_LO && p <= SGR_BGB_HI) bg = cga(p - SGR_BGB_LO, 1);
        end
        attr = rev ? {fg, bg} : {bg, fg};
    endfunction

    function automatic void finish_csi(input logic [7:0] c);
        int unsigned p0, n, here, r, k, cnt;
        if (npar == 0) begin
            npar = 1; par[0] = 0;
        end
        p0 = par[0];
        here = row * W + col;
        cnt = p0 ? p0 : 1;
        case (c)
            FIN_SGR: run_sgr();
            FIN_POS, FIN_POS2: begin
                r = p0 ? p0 : 1;
                k = (npar > 1 && par[1] != 0) ? par[1] : 1;
                if (r > H) r = H;
                if (k > W) k = W;
                row = r - 1; col = k - 1;
            end
            FIN_EDISP: begin
                if (p0 == 1) blank_range(0, here);
                else if (p0 == 2 || p0 == 3) blank_range(0, NCELL - 1);
                else blank_range(here, NCELL - 1);
            end
            FIN_ELINE: begin
                if (p0 == 1) blank_range(row * W, here);
                else if (p0 == 2) blank_range(row * W, row * W + W - 1);
                else blank_range(here, row * W + W - 1);
            end
            FIN_UP: row = (cnt > row) ? 0 : row - cnt;
            FIN_PREVL: begin
                row = (cnt > row) ? 0 : row - cnt; col = 0;
            end
            FIN_DOWN, FIN_NEXTL: begin
                row = (row + cnt >= H) ? H - 1 : row + cnt;
                if (c == FIN_NEXTL) col = 0;
            end
            FIN_RIGHT: col = (col + cnt >= W) ? W - 1 : col + cnt;
            FIN_LEFT: col = (cnt > col) ? 0 : col - cnt;
            FIN_COLUMN: begin
                n = p0 ? p0 - 1 : 0;
                col = (n >= W) ? W - 1 : n;
            end
            FIN_SCRUP, FIN_SCRDN: begin
                n = (cnt > H) ? H : cnt;
                if (c == FIN_SCRUP) roll_up(n); else roll_down(n);
            end
            FIN_SAVE: begin
                srow = row; scol = col;
            end
            FIN_REST: begin
                row = srow; col = scol;
            end
            FIN_SET, FIN_RESET: begin
                if (priv) begin
                    if (p0 == PRIV_CURSOR) shown = (c == FIN_SET);
                    else if (p0 == PRIV_ALT || p0 == PRIV_ALT_OLD) begin
                        if (c == FIN_SET && !alt_on) begin
                            alt = scr;
                            arow = row; acol = col;
                            alt_on = 1;
                            blank_range(0, NCELL - 1);
                            row = 0; col = 0;
                        end else if (c == FIN_RESET && alt_on) begin
                            scr = alt;
                            alt_on = 0;
                            row = arow; col = acol;
                        end
                    end
                end
            end
            default: ;
        endcase
        pst = PS_NORMAL;
        priv = 0;
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        int unsigned v, sp;
        case (pst)
            PS_ESC: begin
                pst = PS_NORMAL;
                if (c == CH_LBRACK) begin
                    pst = PS_CSI; npar = 0; par[0] = 0; priv = 0;
                end else if (c == CH_RBRACK) pst = PS_OSC;
                else if (c == CH_SAVE) begin
                    srow = row; scol = col;
                end else if (c == CH_REST) begin
                    row = srow; col = scol;
                end
                return;
            end
            PS_OSC: begin
                if (c == CH_BEL) pst = PS_NORMAL;
                else if (c == CH_ESC) pst = PS_OSC_ESC;
                return;
            end
            PS_OSC_ESC: begin
                pst = PS_NORMAL;
                return;
            end
            PS_CSI: begin
                if (c == CH_QMARK) priv = 1;
                else if (c >= CH_DIG0 && c <= CH_DIG9) begin
                    if (npar == 0) begin
                        npar = 1; par[0] = 0;
                    end
                    v = par[npar - 1] * 10 + (c - CH_DIG0);
                    par[npar - 1] = (v > 65535) ? 65535 : v;
                end else if (c == CH_SEMI) begin
                    if (npar == 0) begin
                        npar = 1; par[0] = 0;
                    end
                    if (npar < NPAR) begin
                        par[npar] = 0; npar++;
                    end
                end else finish_csi(c);
                return;
            end
            default: pst = PS_NORMAL;
        endcase
        if (c == CH_ESC) pst = PS_ESC;
        else if (c == CH_LF) new_line();
        else if (c == CH_CR) col = 0;
        else if (c == CH_BS) begin
            if (col > 0) begin
                col--;
                scr[row * W + col] = {attr, CH_SPACE};
            end
        end else if (c == CH_TAB) begin
            sp = TABW - (col % TABW);
            for (int unsigned k = 0; k < sp; k++) glyph(CH_SPACE);
        end else glyph(c);
    endfunction

    // Advance the mirror by one item and return the view it should produce
    function automatic t_view predict_view(input t_item it);
        t_view v;
        v.cell_value = '0;
        if (it.command) begin
            if (it.cell_address < NCELL) v.cell_value = scr[it.cell_address];
        end else take_byte(it.char_byte);
        v.cursor_row = row[4:0];
        v.cursor_col = col[6:0];
        v.cursor_visible = shown;
        v.alt_screen_on = alt_on;
        v.current_attribute = attr;
        return v;
    endfunction

    function automatic void mirror_reset();
        for (int i = 0; i < NCELL; i++) begin
            scr[i] = CELL_RESET; alt[i] = '0;
        end
        for (int i = 0; i < NPAR; i++) par[i] = 0;
        pst = PS_NORMAL; npar = 0; priv = 0;
        fg = 7; bg = 0; bold = 0; rev = 0; attr = ATTR_RESET;
        row = 0; col = 0; srow = 0; scol = 0; arow = 0; acol = 0;
        alt_on = 0; shown = 1;
    endfunction

    // Directed table builders
    function automatic void add_row(input t_item it, input bit fixed, input t_view v);
        dir_rows.push_back('{it, fixed, v});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_row('{1'b0, 8'(s[i]), 11'd0}, 0, '0);
    endfunction

    // Clock and cycle limit
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL ansi_text_terminal_engine");
            $finish;
        end
    end

    // Result side: random stalls, compare at the rising edge
    initial begin
        int gap;
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) continue;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            repeat (gap) @(negedge i_clk);
            out_ch.ready <= 1;
            do @(posedge i_clk); while (!out_ch.valid);
            check_view('{out_ch.cell_value, out_ch.cursor_row, out_ch.cursor_col,
                         out_ch.cursor_visible, out_ch.alt_screen_on,
                         out_ch.current_attribute});
            @(negedge i_clk);
            out_ch.ready <= 0;
        end
    end

    task automatic check_view(input t_view got);
        t_view want;
        if (pending_views.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            fails++;
            return;
        end
        want = pending_views.pop_front();
        if (got.cell_value !== want.cell_value) begin
            $display("%0t: cell_value exp %h got %h", $time, want.cell_value, got.cell_value);
            fails++;
        end
        if (got.cursor_row !== want.cursor_row) begin
            $display("%0t: cursor_row exp %0d got %0d", $time, want.cursor_row, got.cursor_row);
            fails++;
        end
        if (got.cursor_col !== want.cursor_col) begin
            $display("%0t: cursor_col exp %0d got %0d", $time, want.cursor_col, got.cursor_col);
            fails++;
        end
        if (got.cursor_visible !== want.cursor_visible) begin
            $display("%0t: cursor_visible exp %b got %b", $time, want.cursor_visible,
                     got.cursor_visible);
            fails++;
        end
        if (got.alt_screen_on !== want.alt_screen_on) begin
            $display("%0t: alt_screen_on exp %b got %b", $time, want.alt_screen_on,
                     got.alt_screen_on);
            fails++;
        end
        if (got.current_attribute !== want.current_attribute) begin
            $display("%0t: current_attribute exp %h got %h", $time, want.current_attribute,
                     got.current_attribute);
            fails++;
        end
    endtask

    // Send one item after a random gap; queue the prediction, or the fixed view, on acceptance
    task automatic send_item(input t_item it, input bit fixed, input t_view fixed_view);
        t_view v;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        repeat (gap) @(negedge i_clk);
        in_ch.command = it.command;
        in_ch.char_byte = it.char_byte;
        in_ch.cell_address = it.cell_address;
        in_ch.valid = 1;
        do @(posedge i_clk); while (!in_ch.ready);
        v = predict_view(it);
        pending_views.push_back(fixed ? fixed_view : v);
        n_sent++;
        @(negedge i_clk);
        in_ch.valid = 0;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_item('{1'b0, b, 11'd0}, 0, '0);
    endtask

    task automatic read_cell(input logic [10:0] a);
        send_item('{1'b1, 8'($urandom_range(0, 255)), a}, 0, '0);
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
    endtask

    // Random well-formed CSI with random content
    task automatic random_csi();
        logic [7:0] finals [19] = '{FIN_UP, FIN_DOWN, FIN_RIGHT, FIN_LEFT, FIN_NEXTL,
            FIN_PREVL, FIN_COLUMN, FIN_POS, FIN_EDISP, FIN_ELINE, FIN_SCRUP, FIN_SCRDN,
            FIN_POS2, FIN_SGR, FIN_SGR, FIN_SAVE, FIN_REST, FIN_SET, FIN_RESET};
        int n;
        logic [7:0] f;
        feed_byte(CH_ESC);
        feed_byte(CH_LBRACK);
        f = finals[$urandom_range(0, 18)];
        if (f == FIN_SET || f == FIN_RESET) begin
            if ($urandom_range(0, 4) != 0) feed_byte(CH_QMARK);
            case ($urandom_range(0, 3))
                0: feed_text("25");
                1: feed_text("1049");
                2: feed_text("47");
                default: feed_text("3");
            endcase
        end else begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                if (i > 0 || $urandom_range(0, 9) == 0) feed_byte(CH_SEMI);
                case ($urandom_range(0, 5))
                    0: ;
                    1: feed_byte(8'(CH_DIG0 + $urandom_range(0, 9)));
                    2, 3: feed_text($sformatf("%0d", $urandom_range(0, 49)));
                    4: feed_text($sformatf("%0d", $urandom_range(90, 107)));
                    default: feed_text($sformatf("%0d", $urandom_range(0, 99999)));
                endcase
            end
        end
        feed_byte(f);
    endtask

    initial begin
        t_view rv;
        bit    drained;
        fails = 0;
        n_sent = 0;
        drained = 0;
        cycles = 0;
        in_ch.valid = 0;
        in_ch.command = 0;
        in_ch.char_byte = 0;
        in_ch.cell_address = 0;
        i_rst_n = 0;
        mirror_reset();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: reset view, address extremes, then parser corners
        rv = '{CELL_RESET, 5'd0, 7'd0, 1'b1, 1'b0, ATTR_RESET};
        add_row('{1'b1, 8'h00, 11'd0}, 1, rv);
        add_row('{1'b1, 8'hFF, 11'd1999}, 1, rv);
        rv.cell_value = '0;
        add_row('{1'b1, 8'h00, 11'd2000}, 1, rv);
        add_row('{1'b1, 8'hA5, 11'h7FF}, 1, rv);
        add_row('{1'b0, 8'hFF, 11'd0}, 0, '0);             // high glyph
        add_row('{1'b0, 8'h01, 11'd0}, 0, '0);             // control byte as glyph
        add_row('{1'b0, CH_TAB, 11'd0}, 0, '0);
        add_row('{1'b0, CH_BS, 11'd0}, 0, '0);
        add_text("\033[;5H");                               // leading semicolon
        add_text("\033[99999;1;2;3;4;5;6;7;8;9;31m");      // saturation and excess params
        add_text("\033]title\033\\");                      // OSC with ESC terminator
        add_text("\033]x\007\033q");                       // OSC with BEL, unknown ESC
        add_text("\033[40S\033[40T\033[?25l\033[?1049h\033[?47h");
        add_text("\033[?1049l\033[?47l\033[?25h\033[\033");
        add_row('{1'b1, 8'h00, 11'd0}, 0, '0);
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].view);

        // Random: mostly well-formed sequences, some raw noise
        while (n_sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: random_csi();
                3: feed_byte(8'($urandom_range(0, 255)));
                4: read_cell(11'($urandom_range(0, 2047)));
                5: begin
                    case ($urandom_range(0, 5))
                        0: feed_byte(CH_LF);
                        1: feed_byte(CH_CR);
                        2: feed_byte(CH_BS);
                        3: feed_byte(CH_TAB);
                        4: feed_text("\0337");
                        default: feed_text("\0338");
                    endcase
                end
                6: begin
                    feed_text("\033]");
                    feed_byte(8'($urandom_range(32, 126)));
                    feed_byte($urandom_range(0, 1) ? CH_BEL : CH_ESC);
                    feed_byte(8'($urandom_range(0, 255)));
                end
                default: feed_byte(8'($urandom_range(32, 126)));
            endcase
            // Hold off once until the pipeline drains
            if (!drained && n_sent > 500) begin
                while (pending_views.size() != 0) @(negedge i_clk);
                drained = 1;
            end
        end
        // Leave with the main screen and sample it
        feed_text("\033[?1049l");
        for (int i = 0; i < 8; i++) read_cell(11'($urandom_range(0, NCELL - 1)));

        while (pending_views.size() != 0) @(negedge i_clk);
        repeat (3 * NCELL) @(negedge i_clk);
        if (fails == 0 && pending_views.size() == 0) begin
            $display("PASS ansi_text_terminal_engine");
        end else begin
            $display("FAIL ansi_text_terminal_engine");
        end
        $finish;
    end

endmodule

### ansi_text_terminal_engine.f
rtl/core/ate_pkg.sv
rtl/core/ate_if.sv
rtl/core/ate_ram.sv
rtl/core/ate_sgr.sv
rtl/core/ansi_text_terminal_engine.sv
sim/tb_ansi_text_terminal_engine.sv
